// ===== src/keyboard_scancode_decoder_macros.svh =====
// Assertion macros for the checker file of the scancode decoder.
`ifndef KEYBOARD_SCANCODE_DECODER_MACROS_SVH
`define KEYBOARD_SCANCODE_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KSD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keyboard_scancode_decoder: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define KSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keyboard_scancode_decoder: assertion failed");

`endif

// ===== src/ksd_pkg.sv =====
package ksd_pkg;

    localparam int NUM_CONSOLES_DEF = 8;

    localparam logic [7:0] SC_LSHIFT = 8'h2A;
    localparam logic [7:0] SC_RSHIFT = 8'h36;
    localparam logic [7:0] SC_BREAK  = 8'h80;
    localparam logic [7:0] SC_PREFIX = 8'hE0;
    localparam logic [7:0] SC_CTRL   = 8'h1D;
    localparam logic [7:0] SC_ALT    = 8'h38;
    localparam logic [7:0] SC_F1     = 8'h3B;
    localparam logic [7:0] SC_UP     = 8'h48;
    localparam logic [7:0] SC_LEFT   = 8'h4B;
    localparam logic [7:0] SC_RIGHT  = 8'h4D;
    localparam logic [7:0] SC_DOWN   = 8'h50;

    localparam logic [6:0] CH_UP    = 7'h1A;
    localparam logic [6:0] CH_LEFT  = 7'h1B;
    localparam logic [6:0] CH_RIGHT = 7'h1D;
    localparam logic [6:0] CH_DOWN  = 7'h1C;

    localparam logic KIND_CHAR   = 1'b0;
    localparam logic KIND_SWITCH = 1'b1;

    localparam logic [7:0] LOCK_MASK_RESET = 8'h80;

    typedef struct packed {
        logic       has_result;
        logic       event_kind;
        logic [6:0] char_code;
        logic [2:0] console_number;
    } ksd_result_t;

    // Unshifted ASCII for a make code; codes not in the table give 0.
    function automatic logic [6:0] plain_char(input logic [6:0] idx);
        logic [6:0] c;
        case (idx)
            7'd2:  c = 7'h31; 7'd3:  c = 7'h32; 7'd4:  c = 7'h33; 7'd5:  c = 7'h34;
            7'd6:  c = 7'h35; 7'd7:  c = 7'h36; 7'd8:  c = 7'h37; 7'd9:  c = 7'h38;
            7'd10: c = 7'h39; 7'd11: c = 7'h30; 7'd12: c = 7'h2D; 7'd13: c = 7'h3D;
            7'd14: c = 7'h08; 7'd15: c = 7'h09;
            7'd16: c = 7'h71; 7'd17: c = 7'h77; 7'd18: c = 7'h65; 7'd19: c = 7'h72;
            7'd20: c = 7'h74; 7'd21: c = 7'h79; 7'd22: c = 7'h75; 7'd23: c = 7'h69;
            7'd24: c = 7'h6F; 7'd25: c = 7'h70; 7'd26: c = 7'h5B; 7'd27: c = 7'h5D;
            7'd28: c = 7'h0A;
            7'd30: c = 7'h61; 7'd31: c = 7'h73; 7'd32: c = 7'h64; 7'd33: c = 7'h66;
            7'd34: c = 7'h67; 7'd35: c = 7'h68; 7'd36: c = 7'h6A; 7'd37: c = 7'h6B;
            7'd38: c = 7'h6C; 7'd39: c = 7'h3B; 7'd40: c = 7'h27; 7'd41: c = 7'h60;
            7'd43: c = 7'h5C; 7'd44: c = 7'h7A; 7'd45: c = 7'h78; 7'd46: c = 7'h63;
            7'd47: c = 7'h76; 7'd48: c = 7'h62; 7'd49: c = 7'h6E; 7'd50: c = 7'h6D;
            7'd51: c = 7'h2C; 7'd52: c = 7'h2E; 7'd53: c = 7'h2F;
            7'd55: c = 7'h2A; 7'd57: c = 7'h20; 7'd74: c = 7'h2D; 7'd78: c = 7'h2B;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

    // Shifted ASCII for a make code; codes not in the table give 0.
    function automatic logic [6:0] shift_char(input logic [6:0] idx);
        logic [6:0] c;
        case (idx)
            7'd2:  c = 7'h21; 7'd3:  c = 7'h40; 7'd4:  c = 7'h23; 7'd5:  c = 7'h24;
            7'd6:  c = 7'h25; 7'd7:  c = 7'h5E; 7'd8:  c = 7'h26; 7'd9:  c = 7'h2A;
            7'd10: c = 7'h28; 7'd11: c = 7'h29; 7'd12: c = 7'h5F; 7'd13: c = 7'h2B;
            7'd14: c = 7'h08; 7'd15: c = 7'h09;
            7'd16: c = 7'h51; 7'd17: c = 7'h57; 7'd18: c = 7'h45; 7'd19: c = 7'h52;
            7'd20: c = 7'h54; 7'd21: c = 7'h59; 7'd22: c = 7'h55; 7'd23: c = 7'h49;
            7'd24: c = 7'h4F; 7'd25: c = 7'h50; 7'd26: c = 7'h7B; 7'd27: c = 7'h7D;
            7'd28: c = 7'h0A;
            7'd30: c = 7'h41; 7'd31: c = 7'h53; 7'd32: c = 7'h44; 7'd33: c = 7'h46;
            7'd34: c = 7'h47; 7'd35: c = 7'h48; 7'd36: c = 7'h4A; 7'd37: c = 7'h4B;
            7'd38: c = 7'h4C; 7'd39: c = 7'h3A; 7'd40: c = 7'h22; 7'd41: c = 7'h7E;
            7'd43: c = 7'h7C; 7'd44: c = 7'h5A; 7'd45: c = 7'h58; 7'd46: c = 7'h43;
            7'd47: c = 7'h56; 7'd48: c = 7'h42; 7'd49: c = 7'h4E; 7'd50: c = 7'h4D;
            7'd51: c = 7'h3C; 7'd52: c = 7'h3E; 7'd53: c = 7'h3F;
            7'd55: c = 7'h2A; 7'd57: c = 7'h20; 7'd74: c = 7'h2D; 7'd78: c = 7'h2B;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== src/ksd_decode.sv =====
module ksd_decode #(
    parameter int NUM_CONSOLES = ksd_pkg::NUM_CONSOLES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [7:0]          cfg_wr_data,
    input  logic                step,
    input  logic [7:0]          scancode,
    output ksd_pkg::ksd_result_t result
);

    logic       lshift_reg, lshift_next;
    logic       rshift_reg, rshift_next;
    logic       lalt_reg, lalt_next;
    logic       ralt_reg, ralt_next;
    logic       prefix_reg, prefix_next;
    logic [2:0] console_reg, console_next;
    logic [7:0] lock_mask_reg;

    logic [7:0] fkey_offset;
    logic       fkey_hit;
    logic [6:0] ch;

    assign fkey_offset = scancode - ksd_pkg::SC_F1;
    assign fkey_hit    = (scancode >= ksd_pkg::SC_F1) && (fkey_offset < 8'(NUM_CONSOLES));

    always_comb
    begin
        lshift_next  = lshift_reg;
        rshift_next  = rshift_reg;
        lalt_next    = lalt_reg;
        ralt_next    = ralt_reg;
        prefix_next  = prefix_reg;
        console_next = console_reg;
        ch           = 7'h00;
        result       = '0;

        if (scancode == ksd_pkg::SC_LSHIFT)
        begin
            lshift_next = 1'b1;
        end
        else if (scancode == ksd_pkg::SC_RSHIFT)
        begin
            rshift_next = 1'b1;
        end
        else if (scancode == (ksd_pkg::SC_LSHIFT | ksd_pkg::SC_BREAK))
        begin
            lshift_next = 1'b0;
        end
        else if (scancode == (ksd_pkg::SC_RSHIFT | ksd_pkg::SC_BREAK))
        begin
            rshift_next = 1'b0;
        end
        else if (prefix_reg)
        begin
            prefix_next = 1'b0;
            case (scancode)
                ksd_pkg::SC_UP:    ch = ksd_pkg::CH_UP;
                ksd_pkg::SC_LEFT:  ch = ksd_pkg::CH_LEFT;
                ksd_pkg::SC_RIGHT: ch = ksd_pkg::CH_RIGHT;
                ksd_pkg::SC_DOWN:  ch = ksd_pkg::CH_DOWN;
                ksd_pkg::SC_ALT:   ralt_next = 1'b1;
                ksd_pkg::SC_ALT | ksd_pkg::SC_BREAK: ralt_next = 1'b0;
                default: ch = 7'h00;
            endcase
        end
        else if (scancode == ksd_pkg::SC_PREFIX)
        begin
            prefix_next = 1'b1;
        end
        else if (scancode == ksd_pkg::SC_CTRL ||
                 scancode == (ksd_pkg::SC_CTRL | ksd_pkg::SC_BREAK))
        begin
            ch = 7'h00;
        end
        else if (scancode == ksd_pkg::SC_ALT)
        begin
            lalt_next = 1'b1;
        end
        else if (scancode == (ksd_pkg::SC_ALT | ksd_pkg::SC_BREAK))
        begin
            lalt_next = 1'b0;
        end
        else if (!scancode[7])
        begin
            if (lalt_reg || ralt_reg)
            begin
                if (fkey_hit)
                begin
                    console_next          = fkey_offset[2:0];
                    result.has_result     = 1'b1;
                    result.event_kind     = ksd_pkg::KIND_SWITCH;
                    result.console_number = fkey_offset[2:0];
                end
            end
            else if (lshift_reg || rshift_reg)
            begin
                ch = ksd_pkg::shift_char(scancode[6:0]);
            end
            else
            begin
                ch = ksd_pkg::plain_char(scancode[6:0]);
            end
        end

        // Characters go to the console that was active before this item.
        if (ch != 7'h00 && !lock_mask_reg[console_reg])
        begin
            result.has_result     = 1'b1;
            result.event_kind     = ksd_pkg::KIND_CHAR;
            result.char_code      = ch;
            result.console_number = console_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lshift_reg    <= 1'b0;
            rshift_reg    <= 1'b0;
            lalt_reg      <= 1'b0;
            ralt_reg      <= 1'b0;
            prefix_reg    <= 1'b0;
            console_reg   <= 3'd0;
            lock_mask_reg <= ksd_pkg::LOCK_MASK_RESET;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                lock_mask_reg <= cfg_wr_data;
            end
            if (step)
            begin
                lshift_reg  <= lshift_next;
                rshift_reg  <= rshift_next;
                lalt_reg    <= lalt_next;
                ralt_reg    <= ralt_next;
                prefix_reg  <= prefix_next;
                console_reg <= console_next;
            end
        end
    end

endmodule

// ===== src/keyboard_scancode_decoder.sv =====
// Channel  | Direction | tdata (low bit up)                          | tuser
// s_axis   | in        | scancode[7:0]                               | -
// m_axis   | out       | char_code[6:0], console_number[9:7], pad 0s | event_kind
// cfg      | in        | cfg_wr_data = console_locked_mask           | -
//
// One scancode is accepted per cycle while s_tready is high; its result passes from the
// input register through the decode into the output register and is offered from there.
// The rate is set by the single decode stage, which also updates the shift, alt,
// prefix and console state as the item leaves the input register.
// Reset clears all key state and sets the lock mask to 0x80; no clearing pass.
// A stalled output holds the item in the input register; s_tready drops only when both
// registers are full and m_tready is low.
module keyboard_scancode_decoder #(
    parameter int NUM_CONSOLES = ksd_pkg::NUM_CONSOLES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // scancode[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // char_code[6:0], console_number[9:7], zeros above
    output logic        m_tuser,   // event_kind
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data
);

    logic                in_valid_reg;
    logic [7:0]          in_code_reg;
    logic                out_valid_reg;
    logic                out_kind_reg;
    logic [6:0]          out_char_reg;
    logic [2:0]          out_console_reg;
    logic                advance;
    ksd_pkg::ksd_result_t result;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    ksd_decode #(
        .NUM_CONSOLES (NUM_CONSOLES)
    ) u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step        (advance),
        .scancode    (in_code_reg),
        .result      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= result.has_result;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_code_reg <= s_tdata;
        end
        if (advance)
        begin
            out_kind_reg    <= result.event_kind;
            out_char_reg    <= result.char_code;
            out_console_reg <= result.console_number;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {6'd0, out_console_reg, out_char_reg};

endmodule

// ===== src/ksd_checker.sv =====
`include "keyboard_scancode_decoder_macros.svh"

module ksd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser
);

    // A result waiting for the sink keeps its contents.
    `KSD_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // A character item never carries the null character.
    `KSD_ASSERT_IMPL(a_char_nonzero, clk, rst_n, m_tvalid && m_tuser == ksd_pkg::KIND_CHAR, m_tdata[6:0] != 7'd0)

    // A console switch carries no character.
    `KSD_ASSERT_IMPL(a_switch_no_char, clk, rst_n, m_tvalid && m_tuser == ksd_pkg::KIND_SWITCH, m_tdata[6:0] == 7'd0)

    // Padding bits above the console number stay zero.
    `KSD_ASSERT_IMPL(a_pad_zero, clk, rst_n, m_tvalid, m_tdata[15:10] == 6'd0)

endmodule

bind keyboard_scancode_decoder ksd_checker u_ksd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== verif/keyboard_scancode_decoder_tb.sv =====
module keyboard_scancode_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CONSOLE_COUNT = ksd_pkg::NUM_CONSOLES_DEF;
    localparam int PIPE_DRAIN    = 4;
    localparam int HOLD_CYCLES   = 80;
    localparam int CYCLE_LIMIT   = 200000;

    typedef struct packed {
        logic       kind;
        logic [6:0] ch;
        logic [2:0] con;
    } key_event_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        cfg_wr_en = 1'b0;
    logic [7:0]  cfg_wr_data = '0;

    // Decoder state as the testbench sees it.
    logic [6:0] key_map [0:1][0:127];
    logic       lshift_down, rshift_down, lalt_down, ralt_down, e0_seen;
    logic [2:0] focus_console;
    logic [7:0] lock_mask;

    key_event_t pending_events[$];
    int         error_count = 0;
    int         cycle_count = 0;

    // Sender and receiver pacing.
    int tx_gap_max = 0;
    int tx_burst_left = 0;
    int rx_ready_pct = 100;
    int hold_req = 0;
    int hold_ack = 0;
    int hold_left = 0;

    keyboard_scancode_decoder #(
        .NUM_CONSOLES(CONSOLE_COUNT)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),     // scancode[7:0]
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),     // char_code[6:0], console_number[9:7], zeros above
        .m_tuser    (m_tuser),     // event_kind
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(1, 100) <= rx_ready_pct);
        end
    end

    task automatic report_mismatch(input string what, input int expected_val, input int got_val);
        $display("[%0t] %s: expected 0x%0h, got 0x%0h", $realtime, what, expected_val, got_val);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        key_event_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_events.size() == 0)
            begin
                report_mismatch("unexpected result item", 0, m_tdata);
            end
            else
            begin
                want = pending_events.pop_front();
                if (m_tuser !== want.kind)
                    report_mismatch("event_kind", want.kind, m_tuser);
                if (m_tdata[6:0] !== want.ch)
                    report_mismatch("char_code", want.ch, m_tdata[6:0]);
                if (m_tdata[9:7] !== want.con)
                    report_mismatch("console_number", want.con, m_tdata[9:7]);
            end
        end
    end

    task automatic put_keys(input int shifted, input int first, input string keys);
        for (int i = 0; i < keys.len(); i++)
            key_map[shifted][first + i] = 7'(keys[i]);
    endtask

    task automatic build_key_maps();
        for (int s = 0; s < 2; s++)
        begin
            for (int i = 0; i < 128; i++)
                key_map[s][i] = 7'h00;
            key_map[s][14] = 7'h08;   // backspace
            key_map[s][15] = 7'h09;   // tab
            key_map[s][28] = 7'h0A;   // enter
            put_keys(s, 55, "*");
            put_keys(s, 57, " ");
            put_keys(s, 74, "-");
            put_keys(s, 78, "+");
        end
        put_keys(0, 2, "1234567890-=");
        put_keys(0, 16, "qwertyuiop[]");
        put_keys(0, 30, "asdfghjkl;'");
        key_map[0][41] = 7'h60;       // grave accent
        put_keys(0, 43, "\\zxcvbnm,./");
        put_keys(1, 2, "!@#$%^&*()_+");
        put_keys(1, 16, "QWERTYUIOP{}");
        put_keys(1, 30, "ASDFGHJKL:\"~");
        put_keys(1, 43, "|ZXCVBNM<>?");
    endtask

    function automatic bit decode_scancode(input logic [7:0] sc, output key_event_t ev);
        logic [6:0] ch;
        ch = 7'h00;
        ev = '0;
        // Shift keys are handled ahead of the prefix and leave it pending.
        if (sc == ksd_pkg::SC_LSHIFT)
        begin
            lshift_down = 1'b1;
            return 1'b0;
        end
        if (sc == ksd_pkg::SC_RSHIFT)
        begin
            rshift_down = 1'b1;
            return 1'b0;
        end
        if (sc == (ksd_pkg::SC_LSHIFT | ksd_pkg::SC_BREAK))
        begin
            lshift_down = 1'b0;
            return 1'b0;
        end
        if (sc == (ksd_pkg::SC_RSHIFT | ksd_pkg::SC_BREAK))
        begin
            rshift_down = 1'b0;
            return 1'b0;
        end

        if (e0_seen)
        begin
            e0_seen = 1'b0;
            case (sc)
                ksd_pkg::SC_UP:    ch = ksd_pkg::CH_UP;
                ksd_pkg::SC_LEFT:  ch = ksd_pkg::CH_LEFT;
                ksd_pkg::SC_RIGHT: ch = ksd_pkg::CH_RIGHT;
                ksd_pkg::SC_DOWN:  ch = ksd_pkg::CH_DOWN;
                ksd_pkg::SC_ALT:   ralt_down = 1'b1;
                ksd_pkg::SC_ALT | ksd_pkg::SC_BREAK: ralt_down = 1'b0;
                default:           ch = 7'h00;
            endcase
        end
        else if (sc == ksd_pkg::SC_PREFIX)
        begin
            e0_seen = 1'b1;
        end
        else if (sc == ksd_pkg::SC_CTRL || sc == (ksd_pkg::SC_CTRL | ksd_pkg::SC_BREAK))
        begin
            ch = 7'h00;
        end
        else if (sc == ksd_pkg::SC_ALT)
        begin
            lalt_down = 1'b1;
        end
        else if (sc == (ksd_pkg::SC_ALT | ksd_pkg::SC_BREAK))
        begin
            lalt_down = 1'b0;
        end
        else if (sc < ksd_pkg::SC_BREAK)
        begin
            if (lalt_down || ralt_down)
            begin
                if (sc >= ksd_pkg::SC_F1 && sc < ksd_pkg::SC_F1 + CONSOLE_COUNT)
                begin
                    focus_console = 3'(sc - ksd_pkg::SC_F1);
                    ev.kind = ksd_pkg::KIND_SWITCH;
                    ev.ch = 7'h00;
                    ev.con = focus_console;
                    return 1'b1;
                end
            end
            else
            begin
                ch = key_map[(lshift_down || rshift_down) ? 1 : 0][sc[6:0]];
            end
        end

        if (ch == 7'h00 || lock_mask[focus_console])
            return 1'b0;
        ev.kind = ksd_pkg::KIND_CHAR;
        ev.ch = ch;
        ev.con = focus_console;
        return 1'b1;
    endfunction

    // Offers one item, waits for it to be taken and records what it should produce.
    task automatic send_scancode(input logic [7:0] sc);
        key_event_t ev;
        s_tvalid <= 1'b1;
        s_tdata <= sc;
        do
            @(posedge clk);
        while (!s_tready);
        if (decode_scancode(sc, ev))
            pending_events.push_back(ev);
        if (tx_gap_max > 0)
        begin
            if (tx_burst_left == 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, tx_gap_max)) @(posedge clk);
                tx_burst_left = $urandom_range(1, 12);
            end
            else
            begin
                tx_burst_left--;
            end
        end
    endtask

    // Stops offering items until every result is back and the pipeline is empty.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_events.size() > 0)
            @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);
    endtask

    task automatic write_lock_mask(input logic [7:0] mask);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= mask;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        lock_mask = mask;
    endtask

    // One key action with random content: mostly well-formed, now and then a broken sequence or a stray byte.
    task automatic type_random_action();
        int pick;
        logic [7:0] key;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 9) < 7)
            key = 8'($urandom_range(2, 57));
        else
            key = 8'($urandom_range(0, 127));
        if (pick < 45)
        begin
            send_scancode(key);
            if ($urandom_range(0, 1))
                send_scancode(key | ksd_pkg::SC_BREAK);
        end
        else if (pick < 60)
        begin
            send_scancode($urandom_range(0, 1) ? ksd_pkg::SC_LSHIFT : ksd_pkg::SC_RSHIFT);
            send_scancode(key);
            send_scancode(key);
            send_scancode($urandom_range(0, 1) ?
                          (ksd_pkg::SC_LSHIFT | ksd_pkg::SC_BREAK) :
                          (ksd_pkg::SC_RSHIFT | ksd_pkg::SC_BREAK));
        end
        else if (pick < 72)
        begin
            key = ksd_pkg::SC_F1 + 8'($urandom_range(0, CONSOLE_COUNT - 1));
            if ($urandom_range(0, 1))
            begin
                send_scancode(ksd_pkg::SC_ALT);
                send_scancode(key);
                send_scancode(ksd_pkg::SC_ALT | ksd_pkg::SC_BREAK);
            end
            else
            begin
                send_scancode(ksd_pkg::SC_PREFIX);
                send_scancode(ksd_pkg::SC_ALT);
                send_scancode(key);
                send_scancode(ksd_pkg::SC_PREFIX);
                send_scancode(ksd_pkg::SC_ALT | ksd_pkg::SC_BREAK);
            end
        end
        else if (pick < 84)
        begin
            send_scancode(ksd_pkg::SC_PREFIX);
            case ($urandom_range(0, 4))
                0:       send_scancode(ksd_pkg::SC_UP);
                1:       send_scancode(ksd_pkg::SC_LEFT);
                2:       send_scancode(ksd_pkg::SC_RIGHT);
                3:       send_scancode(ksd_pkg::SC_DOWN);
                default: send_scancode(8'($urandom_range(0, 255)));
            endcase
        end
        else if (pick < 90)
        begin
            // Broken sequence: a modifier left down, an unmatched release or a lone prefix.
            case ($urandom_range(0, 3))
                0:       send_scancode(ksd_pkg::SC_ALT);
                1:       send_scancode(ksd_pkg::SC_ALT | ksd_pkg::SC_BREAK);
                2:       send_scancode(ksd_pkg::SC_CTRL);
                default: send_scancode(ksd_pkg::SC_PREFIX);
            endcase
        end
        else
        begin
            send_scancode(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_random_actions(input int count);
        for (int i = 0; i < count; i++)
            type_random_action();
    endtask

    task automatic test_reset_state();
        // Lock mask resets with console 7 locked; console 0 is active.
        send_scancode(8'h1E);
        send_scancode(8'h02);
        wait_idle();
    endtask

    task automatic test_directed_keys();
        logic [7:0] codes [$];
        codes = '{ksd_pkg::SC_LSHIFT, 8'h1E, ksd_pkg::SC_PREFIX, ksd_pkg::SC_LSHIFT,
                  ksd_pkg::SC_UP, ksd_pkg::SC_LSHIFT | ksd_pkg::SC_BREAK,
                  ksd_pkg::SC_RSHIFT, 8'h02, ksd_pkg::SC_RSHIFT | ksd_pkg::SC_BREAK,
                  ksd_pkg::SC_PREFIX, ksd_pkg::SC_LEFT,
                  ksd_pkg::SC_PREFIX, ksd_pkg::SC_DOWN, ksd_pkg::SC_PREFIX,
                  ksd_pkg::SC_PREFIX, ksd_pkg::SC_CTRL, 8'h4E, 8'h4F,
                  8'hFF, ksd_pkg::SC_ALT, ksd_pkg::SC_F1 + 8'(CONSOLE_COUNT - 1),
                  ksd_pkg::SC_ALT | ksd_pkg::SC_BREAK,
                  8'h1E, ksd_pkg::SC_PREFIX, ksd_pkg::SC_ALT, ksd_pkg::SC_F1,
                  ksd_pkg::SC_PREFIX, ksd_pkg::SC_ALT | ksd_pkg::SC_BREAK};
        foreach (codes[i])
            send_scancode(codes[i]);
        wait_idle();
    endtask

    task automatic test_lock_mask_extremes();
        write_lock_mask(8'h00);
        run_random_actions(15);
        write_lock_mask(8'hFF);
        run_random_actions(15);
        write_lock_mask(ksd_pkg::LOCK_MASK_RESET);
    endtask

    task automatic test_random_typing();
        // Each phase pairs a newly written lock mask with a different idling pattern.
        write_lock_mask(8'($urandom_range(0, 255)));
        tx_gap_max = 0;
        rx_ready_pct = 100;
        run_random_actions(30);
        write_lock_mask(8'($urandom_range(0, 255)));
        tx_gap_max = 4;
        rx_ready_pct = 60;
        run_random_actions(30);
        write_lock_mask(8'h00);
        tx_gap_max = 2;
        rx_ready_pct = 85;
        run_random_actions(30);
        write_lock_mask(8'($urandom_range(0, 255)));
        tx_gap_max = 6;
        rx_ready_pct = 30;
        run_random_actions(30);
    endtask

    task automatic test_backpressure();
        write_lock_mask(8'h00);
        tx_gap_max = 0;
        rx_ready_pct = 100;
        hold_req++;
        for (int i = 0; i < 30; i++)
            send_scancode(8'($urandom_range(2, 57)));
        wait_idle();
        tx_gap_max = 3;
        rx_ready_pct = 50;
        hold_req++;
        run_random_actions(20);
        wait_idle();
    endtask

    initial
    begin
        build_key_maps();
        lshift_down = 1'b0;
        rshift_down = 1'b0;
        lalt_down = 1'b0;
        ralt_down = 1'b0;
        e0_seen = 1'b0;
        focus_console = 3'd0;
        lock_mask = ksd_pkg::LOCK_MASK_RESET;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_directed_keys();
        test_lock_mask_extremes();
        test_random_typing();
        test_backpressure();

        wait_idle();
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
